// ----- design/dq_pkg.sv -----
// Package for the double-ended queue: command and status codes, controller
// state type, command struct between controller and datapath.
// No dependencies.
`default_nettype none

package dq_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 8;
   localparam int COUNT_W = 9;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_POP_FRONT  = 3'd1,
      CMD_PUSH_BACK  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_READ_AT    = 3'd4,
      CMD_CLEAR      = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic exec;      // item accepted: update pointers, touch the ring
      logic load_rsp;  // move finished result into the output register
   } ctrl_type;

endpackage

`default_nettype wire

// ----- design/dq_if.sv -----
// Valid/ready channel interfaces for the double-ended queue.
// Depends on dq_pkg.
`default_nettype none

interface dq_req_if;
   import dq_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [2:0]                cmd;
   logic signed [VALUE_W-1:0] push_value;
   logic [POS_W-1:0]          position;

   modport source (output valid, output cmd, output push_value, output position,
                   input ready);
   modport sink   (input valid, input cmd, input push_value, input position,
                   output ready);
endinterface

interface dq_rsp_if;
   import dq_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] result_value;
   logic [1:0]                status;
   logic [COUNT_W-1:0]        count;

   modport source (output valid, output result_value, output status, output count,
                   input ready);
   modport sink   (input valid, input result_value, input status, input count,
                   output ready);
endinterface

`default_nettype wire

// ----- design/double_ended_queue_top.sv -----
// Top level of the bounded double-ended queue: controller plus datapath.
// Depends on dq_pkg, dq_req_if, dq_rsp_if, dq_ctrl, dq_dpath.
//
//   channel  dir  handshake    payload
//   req_ch   in   valid/ready  cmd[2:0], push_value[31:0], position[7:0]
//   rsp_ch   out  valid/ready  result_value[31:0], status[1:0], count[8:0]
//
// An item is first accepted (pointer update and one ring access on the
// single-port store); then the registered read data is formed into the result.
// A new item is accepted while the previous result still sits in the output
// register; an item waits in the respond state while that register is full.
// Synchronous reset empties the queue; the store itself is not cleared.
`default_nettype none

module double_ended_queue_top #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   dq_req_if.sink   req_ch,
   dq_rsp_if.source rsp_ch
);
   import dq_pkg::*;

   ctrl_type ctrl;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .ctrl      (ctrl)
   );

   dq_dpath #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .req_cmd          (req_ch.cmd),
      .req_push_value   (req_ch.push_value),
      .req_position     (req_ch.position),
      .rsp_result_value (rsp_ch.result_value),
      .rsp_status       (rsp_ch.status),
      .rsp_count        (rsp_ch.count)
   );

endmodule

`default_nettype wire

// ----- design/dq_ctrl.sv -----
// Controller of the double-ended queue: accept/respond state machine and
// output valid register. Depends on dq_pkg.
`default_nettype none

module dq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      dq_pkg::ctrl_type ctrl
);
   import dq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_RESP;
         ST_RESP: if (out_free)  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      ctrl.exec     = (state_ff == ST_IDLE) && req_valid;
      ctrl.load_rsp = (state_ff == ST_RESP) && out_free;
      if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a second item before the first was answered");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_rsp |=> rsp_valid)
      else $error("loaded result not presented");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while waiting");

endmodule

`default_nettype wire

// ----- design/dq_dpath.sv -----
// Datapath of the double-ended queue: ring store, front pointer, count,
// address arithmetic and result registers. Depends on dq_pkg.
`default_nettype none

module dq_dpath #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dq_pkg::ctrl_type                  ctrl,
   input  wire logic [2:0]                        req_cmd,
   input  wire logic signed [dq_pkg::VALUE_W-1:0] req_push_value,
   input  wire logic [dq_pkg::POS_W-1:0]          req_position,
   output      logic signed [dq_pkg::VALUE_W-1:0] rsp_result_value,
   output      logic [1:0]                        rsp_status,
   output      logic [dq_pkg::COUNT_W-1:0]        rsp_count
);
   import dq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam int XW = (WIDTH > VALUE_W) ? WIDTH : VALUE_W;

   logic [WIDTH-1:0] mem [DEPTH];

   logic [AW-1:0]   front_ff, front_in;
   logic [CW-1:0]   count_ff, count_in;
   status_type      status_ff, status_in;
   logic            rd_ok_ff, rd_ok_in;
   logic [WIDTH-1:0] rd_data_ff;

   logic signed [VALUE_W-1:0] rsp_value_ff;
   status_type                rsp_status_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   logic            is_empty, is_full, pos_bad;
   logic [AW-1:0]   front_dec, front_inc, ring_addr, mem_addr;
   logic [CW-1:0]   offset;
   logic [CW:0]     sum;
   logic            use_dec, we, re;
   logic [XW-1:0]   push_ext, rd_ext;

   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CW'(DEPTH));
   assign pos_bad   = (PW'(req_position) >= PW'(count_ff));
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + 1'b1;

   // front + offset modulo DEPTH; offset is below DEPTH whenever the ring is accessed
   assign sum       = (CW+1)'(front_ff) + (CW+1)'(offset);
   assign ring_addr = (sum >= (CW+1)'(DEPTH)) ? AW'(sum - (CW+1)'(DEPTH)) : AW'(sum);
   assign mem_addr  = use_dec ? front_dec : ring_addr;

   // pushes keep the low WIDTH bits of the unsigned pattern
   assign push_ext  = XW'($unsigned(req_push_value));
   assign rd_ext    = XW'($signed(rd_data_ff));

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = STAT_OK;
      rd_ok_in  = 1'b0;
      offset    = '0;
      use_dec   = 1'b0;
      we        = 1'b0;
      re        = 1'b0;
      unique case (cmd_type'(req_cmd))
         CMD_PUSH_FRONT: begin
            use_dec = 1'b1;
            if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               we       = 1'b1;
               front_in = front_dec;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (is_empty) begin
               status_in = STAT_EMPTY;
            end else begin
               re       = 1'b1;
               rd_ok_in = 1'b1;
               front_in = front_inc;
               count_in = count_ff - 1'b1;
            end
         end
         CMD_PUSH_BACK: begin
            offset = count_ff;
            if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               we       = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_BACK: begin
            offset = count_ff - 1'b1;
            if (is_empty) begin
               status_in = STAT_EMPTY;
            end else begin
               re       = 1'b1;
               rd_ok_in = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         CMD_READ_AT: begin
            // only used when position < count, so it fits in CW bits
            offset = CW'(req_position);
            if (pos_bad) begin
               status_in = STAT_RANGE;
            end else begin
               re       = 1'b1;
               rd_ok_in = 1'b1;
            end
         end
         CMD_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (ctrl.exec) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         status_ff <= status_in;
         rd_ok_ff  <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec && we) begin
         mem[mem_addr] <= push_ext[WIDTH-1:0];
      end
      if (ctrl.exec && re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         rsp_value_ff  <= rd_ok_ff ? $signed(rd_ext[VALUE_W-1:0]) : '0;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count        = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= AW'(DEPTH - 1))
      else $error("front pointer outside the ring");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.exec && we |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow the count");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench for double_ended_queue_top: random and directed deque commands,
// checked against a scoreboard that tracks the queue contents.
// Depends on dq_pkg, dq_if and the design files.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dq_pkg::*;

   localparam int QUEUE_DEPTH = 256;
   localparam int PHASE_LEN   = 210;
   localparam int HOLD_AT     = 470;
   localparam int HOLD_CYCLES = 80;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 10;
   // codes the block decodes as no-ops
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      status_type                status;
      logic [COUNT_W-1:0]        count;
   } deque_result_type;

   class deque_scoreboard;
      logic [VALUE_W-1:0] ring_store [QUEUE_DEPTH];
      logic [POS_W-1:0]   head;
      logic [COUNT_W-1:0] held;
      deque_result_type   expected_results[$];
      int                 errors, checked, n_full, n_empty, n_range;

      function new();
         head = '0;
         held = '0;
         errors = 0;
         checked = 0;
         n_full = 0;
         n_empty = 0;
         n_range = 0;
      endfunction

      // apply one accepted command and queue the result it must produce
      function void note(logic [2:0] code, logic [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
         deque_result_type r;
         logic [POS_W-1:0] slot;
         r.value = '0;
         r.status = STAT_OK;
         case (code)
            CMD_PUSH_FRONT: begin
               if (held == QUEUE_DEPTH) r.status = STAT_FULL;
               else begin
                  head = head - 1'b1;
                  ring_store[head] = val;
                  held = held + 1'b1;
               end
            end
            CMD_POP_FRONT: begin
               if (held == 0) r.status = STAT_EMPTY;
               else begin
                  r.value = ring_store[head];
                  head = head + 1'b1;
                  held = held - 1'b1;
               end
            end
            CMD_PUSH_BACK: begin
               if (held == QUEUE_DEPTH) r.status = STAT_FULL;
               else begin
                  slot = head + held[POS_W-1:0];
                  ring_store[slot] = val;
                  held = held + 1'b1;
               end
            end
            CMD_POP_BACK: begin
               if (held == 0) r.status = STAT_EMPTY;
               else begin
                  slot = head + held[POS_W-1:0] - 1'b1;
                  r.value = ring_store[slot];
                  held = held - 1'b1;
               end
            end
            CMD_READ_AT: begin
               if ({1'b0, pos} >= held) r.status = STAT_RANGE;
               else begin
                  slot = head + pos;
                  r.value = ring_store[slot];
               end
            end
            CMD_CLEAR: begin
               head = '0;
               held = '0;
            end
            default: ;
         endcase
         r.count = held;
         if (r.status == STAT_FULL) n_full++;
         if (r.status == STAT_EMPTY) n_empty++;
         if (r.status == STAT_RANGE) n_range++;
         expected_results.push_back(r);
      endfunction

      function void check(logic signed [VALUE_W-1:0] value, logic [1:0] status,
                          logic [COUNT_W-1:0] count);
         deque_result_type e;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected item: value %0d status %0d count %0d",
                     $time, value, status, count);
            errors++;
            return;
         end
         e = expected_results.pop_front();
         checked++;
         if (value !== e.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d", $time, e.value, value);
            errors++;
         end
         if (status !== e.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, status);
            errors++;
         end
         if (count !== e.count) begin
            $display("%0t: count mismatch: expected %0d, actual %0d", $time, e.count, count);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   dq_req_if req_ch();
   dq_rsp_if rsp_ch();

   double_ended_queue_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   deque_scoreboard queue_model = new();

   int send_idle_pct = 10;
   int recv_idle_pct = 85;
   int sent = 0;
   int hold_left = 0;
   int stall_cycles = 0;
   bit hold_request = 1'b0;

   always #2 clock = ~clock;

   task automatic send_item(input logic [2:0] code, input logic [VALUE_W-1:0] val,
                            input logic [POS_W-1:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= code;
      req_ch.push_value <= val;
      req_ch.position   <= pos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      queue_model.note(code, val, pos);
      sent++;
      if (sent == PHASE_LEN) begin
         send_idle_pct = 85;
         recv_idle_pct = 10;
      end else if (sent == 2 * PHASE_LEN) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      if (sent == HOLD_AT) hold_request = 1'b1;
   endtask

   // mostly positions near the live range, some far beyond it
   function automatic logic [POS_W-1:0] pick_position();
      int r;
      int held;
      r = $urandom_range(99);
      held = int'(queue_model.held);
      if (r < 40 || held == 0) return POS_W'($urandom_range(255));
      if (r < 70) return POS_W'($urandom_range(held - 1));
      if (r < 85) return POS_W'(held - 1);
      return (held > 255) ? 8'd255 : POS_W'(held);
   endfunction

   task automatic send_random(input logic [2:0] code);
      send_item(code, $urandom, pick_position());
   endtask

   // weights: pushes, pops, reads, then spare codes; no clear
   task automatic send_biased(input int push_pct, input int pop_pct, input int read_pct);
      int r;
      r = $urandom_range(99);
      if (r < push_pct)
         send_random($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT);
      else if (r < push_pct + pop_pct)
         send_random($urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT);
      else if (r < push_pct + pop_pct + read_pct)
         send_random(CMD_READ_AT);
      else
         send_random($urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6);
   endtask

   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready)
         queue_model.check(rsp_ch.result_value, rsp_ch.status, rsp_ch.count);
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("FAIL double_ended_queue_top");
         $finish;
      end
   end

   initial begin
      req_ch.valid      <= 1'b0;
      req_ch.cmd        <= CMD_CLEAR;
      req_ch.push_value <= '0;
      req_ch.position   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue corners
      send_random(CMD_POP_FRONT);
      send_random(CMD_POP_BACK);
      send_item(CMD_READ_AT, $urandom, 8'd0);
      // front push from empty wraps the head pointer
      send_item(CMD_PUSH_FRONT, 32'h7FFF_FFFF, POS_W'($urandom));
      send_item(CMD_PUSH_BACK, 32'h8000_0000, POS_W'($urandom));
      send_item(CMD_PUSH_FRONT, 32'h0000_0000, POS_W'($urandom));
      send_item(CMD_PUSH_BACK, 32'hFFFF_FFFF, POS_W'($urandom));
      send_item(CMD_READ_AT, $urandom, 8'd0);
      send_item(CMD_READ_AT, $urandom, 8'd3);
      send_item(CMD_READ_AT, $urandom, 8'd4);
      send_item(CMD_READ_AT, $urandom, 8'd255);
      send_item(CMD_SPARE_6, $urandom, POS_W'($urandom));
      send_item(CMD_SPARE_7, $urandom, POS_W'($urandom));
      send_random(CMD_POP_BACK);
      send_random(CMD_POP_FRONT);
      send_random(CMD_CLEAR);
      send_item(CMD_READ_AT, $urandom, 8'd0);
      send_random(CMD_CLEAR);
      send_item(CMD_PUSH_BACK, 32'h5555_5555, POS_W'($urandom));
      send_item(CMD_PUSH_FRONT, 32'hAAAA_AAAA, POS_W'($urandom));
      send_item(CMD_READ_AT, $urandom, 8'd1);
      send_random(CMD_POP_FRONT);
      send_random(CMD_POP_BACK);
      send_random(CMD_POP_FRONT);

      // fill to the brim, then bounce off full
      while (queue_model.held < QUEUE_DEPTH) send_biased(96, 1, 2);
      repeat (4) send_random($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT);
      repeat (3) send_random(CMD_READ_AT);
      // drain to empty, then bounce off empty
      while (queue_model.held > 0) send_biased(1, 95, 3);
      repeat (3) send_random($urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT);
      // mixed traffic with the odd clear
      repeat (20) begin
         if ($urandom_range(99) < 5) send_random(CMD_CLEAR);
         else send_biased(45, 30, 20);
      end
      req_ch.valid <= 1'b0;

      while (queue_model.expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d commands, checked %0d results, %0d errors",
               sent, queue_model.checked, queue_model.errors);
      $display("Status hits: full %0d, empty %0d, out of range %0d",
               queue_model.n_full, queue_model.n_empty, queue_model.n_range);
      if (queue_model.errors == 0)
         $display("PASS double_ended_queue_top");
      else
         $display("FAIL double_ended_queue_top");
      $finish;
   end

endmodule

`default_nettype wire
